// ===== rtl/vwws_pkg.sv =====
// Shared constants, types and codes of the voiced window word segmenter.
`default_nettype none
package vwws_pkg;

    localparam int WINDOW    = 26;
    localparam int PTR_W     = $clog2(WINDOW);
    localparam int CNT_W     = $clog2(WINDOW + 1);
    localparam int TH_W      = 5;
    localparam int CMP_W     = ((CNT_W > TH_W) ? CNT_W : TH_W) + 1;
    localparam int SAMPLE_W  = 16;
    localparam int PEAK_W    = 16;
    localparam int FRAMES_W  = 16;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_START = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END   = 1'd1;

    localparam logic [TH_W-1:0] START_RESET = 5'd12;
    localparam logic [TH_W-1:0] END_RESET   = 5'd2;

    localparam logic [1:0] EV_IDLE   = 2'd0;
    localparam logic [1:0] EV_START  = 2'd1;
    localparam logic [1:0] EV_APPEND = 2'd2;
    localparam logic [1:0] EV_END    = 2'd3;

    // controller to datapath
    typedef struct packed {
        logic accept;      // input request taken this cycle
        logic write_slot;  // store frame into ring, add its flag
        logic decide;      // word decision and window bookkeeping
        logic scan;        // issue one ring read
        logic emit;        // load the output register
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic start_hit;   // idle and count reached start threshold
        logic scan_last;   // last ring slot being read
        logic out_free;    // output register can take a result
    } t_status;

endpackage
`default_nettype wire

// ===== rtl/vwws_ctrl.sv =====
// Sequencer of the word segmenter: accept, store, decide, scan, emit.
`default_nettype none
module vwws_ctrl
    import vwws_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    input  wire logic    i_in_last,
    input  wire t_status i_status,
    output logic         o_in_ready,
    output t_cmd         o_cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_WRITE  = 3'd1;
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_SCAN   = 3'd3;
    localparam logic [2:0] S_DRAIN  = 3'd4;
    localparam logic [2:0] S_EMIT   = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state          = r_state;
        o_in_ready       = 1'b0;
        o_cmd            = '0;
        case (r_state)
            S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
                if (i_in_valid && i_in_last) begin
                    n_state = S_WRITE;
                end
            end
            S_WRITE: begin
                o_cmd.write_slot = 1'b1;
                n_state          = S_DECIDE;
            end
            S_DECIDE: begin
                o_cmd.decide = 1'b1;
                n_state      = i_status.start_hit ? S_SCAN : S_EMIT;
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_status.scan_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/vwws_dp.sv =====
// Datapath: frame peak, window ring, voiced count, word registers, output stage.
`default_nettype none
module vwws_dp
    import vwws_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_cmd                 i_cmd,
    output t_status                   o_status,
    input  wire logic [SAMPLE_W-1:0]  i_sample,
    input  wire logic                 i_last,
    input  wire logic                 i_voiced,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [TH_W-1:0]      i_cfg_data,
    input  wire logic                 i_out_ready,
    output logic                      o_out_valid,
    output logic [1:0]                o_out_ev,
    output logic [FRAMES_W-1:0]       o_out_frames,
    output logic [PEAK_W-1:0]         o_out_wpeak,
    output logic [PEAK_W-1:0]         o_out_fpeak
);

    logic [TH_W-1:0]     r_cfg_start;
    logic [TH_W-1:0]     r_cfg_end;
    logic [PEAK_W-1:0]   r_run_peak;
    logic [PEAK_W-1:0]   r_fpeak;
    logic                r_voiced;
    logic [WINDOW-1:0]   r_flags;
    logic [WINDOW-1:0]   r_pvalid;
    logic [PEAK_W-1:0]   r_ring [WINDOW];
    logic [PTR_W-1:0]    r_ptr;
    logic [CNT_W-1:0]    r_count;
    logic                r_active;
    logic [FRAMES_W-1:0] r_wfc;
    logic [PEAK_W-1:0]   r_wpk;
    logic [1:0]          r_ev;
    logic [PTR_W-1:0]    r_scan;
    logic                r_rd_live;
    logic                r_rd_ok;
    logic [PEAK_W-1:0]   r_rd_data;
    logic                r_out_valid;
    logic [1:0]          r_out_ev;
    logic [FRAMES_W-1:0] r_out_wf;
    logic [PEAK_W-1:0]   r_out_wp;
    logic [PEAK_W-1:0]   r_out_fp;

    logic [PEAK_W-1:0]   n_abs;
    logic [PEAK_W-1:0]   n_fpeak;
    logic [PTR_W-1:0]    n_nxt;
    logic [CMP_W-1:0]    n_cnt_x;
    logic [CMP_W-1:0]    n_start_x;
    logic [CMP_W-1:0]    n_end_x;
    logic [PEAK_W-1:0]   n_scan_val;
    logic                n_start;
    logic                n_end;

    // most negative sample maps to 0x8000, which is its magnitude
    assign n_abs     = i_sample[SAMPLE_W-1] ? (~i_sample + 16'd1) : i_sample;
    assign n_fpeak   = (n_abs > r_run_peak) ? n_abs : r_run_peak;
    assign n_nxt     = (r_ptr == PTR_W'(WINDOW - 1)) ? '0 : r_ptr + 1'b1;
    assign n_cnt_x   = CMP_W'(r_count);
    assign n_start_x = CMP_W'(r_cfg_start);
    assign n_end_x   = CMP_W'(r_cfg_end);
    assign n_start   = !r_active && (n_cnt_x >= n_start_x);
    assign n_end     = r_active && (n_cnt_x <= n_end_x);
    assign n_scan_val = r_rd_ok ? r_rd_data : '0;

    assign o_status.start_hit = n_start;
    assign o_status.scan_last = (r_scan == PTR_W'(WINDOW - 1));
    assign o_status.out_free  = !r_out_valid || i_out_ready;

    // ring memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.write_slot) begin
            r_ring[r_ptr] <= r_fpeak;
        end
        r_rd_data <= r_ring[r_scan];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_start <= START_RESET;
            r_cfg_end   <= END_RESET;
            r_run_peak  <= '0;
            r_fpeak     <= '0;
            r_voiced    <= 1'b0;
            r_flags     <= '0;
            r_pvalid    <= '0;
            r_ptr       <= '0;
            r_count     <= '0;
            r_active    <= 1'b0;
            r_wfc       <= '0;
            r_wpk       <= '0;
            r_ev        <= EV_IDLE;
            r_scan      <= '0;
            r_rd_live   <= 1'b0;
            r_rd_ok     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_START: r_cfg_start <= i_cfg_data;
                    CFG_END:   r_cfg_end   <= i_cfg_data;
                    default: begin
                    end
                endcase
            end

            if (i_cmd.accept) begin
                if (i_last) begin
                    r_fpeak    <= n_fpeak;
                    r_voiced   <= i_voiced;
                    r_run_peak <= '0;
                end else begin
                    r_run_peak <= n_fpeak;
                end
            end

            if (i_cmd.write_slot) begin
                r_flags[r_ptr]  <= r_voiced;
                r_pvalid[r_ptr] <= 1'b1;
                r_count         <= r_count + CNT_W'(r_voiced);
            end

            if (i_cmd.decide) begin
                r_scan <= '0;
                if (n_start) begin
                    r_active <= 1'b1;
                    r_wfc    <= FRAMES_W'(WINDOW);
                    r_wpk    <= '0;
                    r_ev     <= EV_START;
                end else if (n_end) begin
                    r_active <= 1'b0;
                    r_ev     <= EV_END;
                end else if (r_active) begin
                    if (r_wfc != '1) begin
                        r_wfc <= r_wfc + 1'b1;
                    end
                    if (r_fpeak > r_wpk) begin
                        r_wpk <= r_fpeak;
                    end
                    r_ev <= EV_APPEND;
                end else begin
                    r_ev <= EV_IDLE;
                end
                // drop the oldest flag from the count and advance the slot
                if (r_count >= CNT_W'(r_flags[n_nxt])) begin
                    r_count <= r_count - CNT_W'(r_flags[n_nxt]);
                end else begin
                    r_count <= '0;
                end
                r_ptr <= n_nxt;
            end

            if (i_cmd.scan) begin
                r_scan <= r_scan + 1'b1;
            end
            r_rd_live <= i_cmd.scan;
            r_rd_ok   <= r_pvalid[r_scan];
            if (r_rd_live && (n_scan_val > r_wpk)) begin
                r_wpk <= n_scan_val;
            end

            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // output payload, held while the receiver stalls
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_ev <= r_ev;
            r_out_wf <= (r_ev == EV_IDLE) ? '0 : r_wfc;
            r_out_wp <= (r_ev == EV_IDLE) ? '0 : r_wpk;
            r_out_fp <= r_fpeak;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_ev     = r_out_ev;
    assign o_out_frames = r_out_wf;
    assign o_out_wpeak  = r_out_wp;
    assign o_out_fpeak  = r_out_fp;

endmodule
`default_nettype wire

// ===== rtl/voiced_window_word_segmenter.sv =====
// Top level of the voiced window word segmenter.
//
// Usage:
//   Slave stream carries one audio sample per request: tdata is the signed
//   sample, tlast marks the last sample of a frame and tuser carries the
//   upstream voice decision for that frame.
//   Master stream carries one result per frame: tuser is the event code
//   (idle, word started, frame appended, word ended), tdata holds the word
//   frame count, the word peak and the frame peak.
//   Configuration writes (start and end thresholds) go in while idle.
// Flow:
//   A sample that does not end a frame is taken while idle; such samples may
//   stream back to back, but not while a frame end is in work. A frame end
//   passes the write, decide and emit steps; when a word starts, a serial scan
//   of the peak ring through its single read port and a drain step come first.
// Reset:
//   Synchronous, active low. Clears the window ring flags, counts, word
//   state and thresholds to their defaults (start 12, end 2).
// Stall:
//   The result sits in an output register; samples keep flowing while it
//   waits. A further frame end is held in the emit step until it drains.
`default_nettype none
module voiced_window_word_segmenter
    import vwws_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // fields from bit 0: sample[15:0]
    input  wire logic [15:0]          s_axis_tdata,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic                 s_axis_tlast,
    // fields from bit 0: frame_voiced[0]
    input  wire logic                 s_axis_tuser,
    // fields from bit 0: word_frames[15:0], word_peak[31:16], frame_peak[47:32]
    output logic [47:0]               m_axis_tdata,
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    // fields from bit 0: event_res[1:0]
    output logic [1:0]                m_axis_tuser,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [TH_W-1:0]      i_cfg_data
);

    t_cmd                w_cmd;
    t_status             w_status;
    logic [FRAMES_W-1:0] w_frames;
    logic [PEAK_W-1:0]   w_wpeak;
    logic [PEAK_W-1:0]   w_fpeak;

    vwws_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_last  (s_axis_tlast),
        .i_status   (w_status),
        .o_in_ready (s_axis_tready),
        .o_cmd      (w_cmd)
    );

    vwws_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .i_sample     (s_axis_tdata),
        .i_last       (s_axis_tlast),
        .i_voiced     (s_axis_tuser),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_out_ready  (m_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .o_out_ev     (m_axis_tuser),
        .o_out_frames (w_frames),
        .o_out_wpeak  (w_wpeak),
        .o_out_fpeak  (w_fpeak)
    );

    // pack results, first field lowest
    assign m_axis_tdata = {w_fpeak, w_wpeak, w_frames};

    // a frame end request parks the input until its result is built
    a_frame_end_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !s_axis_tready)
        else $error("input ready right after a frame end request");

    // a new result appears only after the emit command
    a_valid_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(w_cmd.emit))
        else $error("output valid rose without an emit");

    // emit never overwrites a result still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit |-> (!m_axis_tvalid || m_axis_tready))
        else $error("emit while output stalled");

    // idle events carry zero word fields
    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser == EV_IDLE)) |-> (m_axis_tdata[31:0] == 32'd0))
        else $error("idle event with nonzero word fields");

endmodule
`default_nettype wire
